/* src/assert_macros.svh */
// Assertion macros used by the rotator RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/sir90_pkg.sv */
// Shared constants for the square image rotator.
// No dependencies.
package sir90_pkg;

  localparam int DATA_W     = 32;
  localparam int SIDE_W     = 4;
  localparam int SIDE_RESET = 8;

endpackage

/* src/sir90_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sir90_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable; hold read data unless a read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/square_image_rotate_90_clockwise.sv */
// Square matrix rotator, 90 degrees clockwise, around one frame store.
// Depends on sir90_pkg, sir90_ram and assert_macros.svh.
//
// Usage:
//   Elements of an n x n matrix enter on the s_ channel in row-major order,
//   n set by cfg_we/cfg_wdata (0 acts as 1, above MAX_SIDE acts as MAX_SIDE).
//   Write the side only while the block is idle.
//   While loading, one element is taken per cycle and written to the store.
//   The transfer of the n*n-th element starts the read-out: the rotated
//   matrix leaves on the m_ channel in row-major order, m_tlast on its final
//   element. After that transfer the first store read is issued, and its
//   data passes through the store's read register into the output register,
//   raising m_tvalid; then one result per cycle while m_tready stays high,
//   one store read each. s_tready is low until the last store read is issued,
//   so no new element is taken while the previous frame is still read out.
//   A stalled receiver holds the output register; reads pause so that no
//   fetched element is lost, and resume when the output is taken.
//   Reset clears the load count and the read-out, and sets the side to 8;
//   store contents are undefined but never read before they are written.
module square_image_rotate_90_clockwise #(
  parameter int MAX_SIDE = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration: side_length
  input  logic                       cfg_we,
  input  logic [sir90_pkg::SIDE_W-1:0] cfg_wdata,
  // Input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [sir90_pkg::DATA_W-1:0] s_tdata,  // [31:0] pixel_value
  // Output stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sir90_pkg::DATA_W-1:0] m_tdata,  // [31:0] rotated_value
  output logic                       m_tlast     // last_of_frame
);

  import sir90_pkg::*;

`include "assert_macros.svh"

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  typedef enum logic {ST_LOAD, ST_EMIT} state_t;

  state_t              state;
  logic [SIDE_W-1:0]   side_length;
  logic [SIDE_W-1:0]   n_eff;
  logic [CW-1:0]       n_cw;
  logic [CW-1:0]       total;
  logic [CW-1:0]       row_base;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [IW-1:0]       row_i;
  logic [IW-1:0]       col_j;
  logic [CW-1:0]       rd_addr;
  logic                last_col;
  logic                last_row;
  logic                in_xfer;
  logic                pend;
  logic                pend_last;
  logic                pend_move;
  logic                rd_issue;
  logic [DATA_W-1:0]   rd_data;

  // Clamp the configured side into 1..MAX_SIDE.
  always_comb begin
    if (side_length == '0) begin
      n_eff = SIDE_W'(1);
    end else if (side_length > SIDE_W'(MAX_SIDE)) begin
      n_eff = SIDE_W'(MAX_SIDE);
    end else begin
      n_eff = side_length;
    end
  end

  assign n_cw     = CW'(n_eff);
  assign total    = CW'(n_cw * n_cw);
  assign row_base = total - n_cw;

  // Handshake and sequencing terms.
  assign s_tready   = (state == ST_LOAD);
  assign in_xfer    = s_tvalid && s_tready;
  assign count_next = count + CW'(1);
  assign last_col   = (CW'(col_j) == n_cw - CW'(1));
  assign last_row   = (CW'(row_i) == n_cw - CW'(1));
  assign pend_move  = pend && (!m_tvalid || m_tready);
  assign rd_issue   = (state == ST_EMIT) && (!pend || pend_move);

  sir90_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (count[AW-1:0]),
    .wdata (s_tdata),
    .re    (rd_issue),
    .raddr (rd_addr[AW-1:0]),
    .rdata (rd_data)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= SIDE_W'(SIDE_RESET);
    end else if (cfg_we) begin
      side_length <= cfg_wdata;
    end
  end

  // Load counter and read-out sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      row_i <= '0;
      col_j <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (count_next >= total) begin
              count   <= '0;
              row_i   <= '0;
              col_j   <= '0;
              rd_addr <= row_base;
              state   <= ST_EMIT;
            end else begin
              count <= count_next;
            end
          end
        end
        ST_EMIT: begin
          if (rd_issue) begin
            if (last_col) begin
              col_j   <= '0;
              row_i   <= row_i + IW'(1);
              rd_addr <= row_base + CW'(row_i) + CW'(1);
              if (last_row) begin
                state <= ST_LOAD;
              end
            end else begin
              col_j   <= col_j + IW'(1);
              rd_addr <= rd_addr - n_cw;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Track the fetched element and advance it into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rd_issue) begin
        pend      <= 1'b1;
        pend_last <= last_col && last_row;
      end else if (pend_move) begin
        pend <= 1'b0;
      end
      if (pend_move) begin
        m_tvalid <= 1'b1;
        m_tdata  <= rd_data;
        m_tlast  <= pend_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Checks.
  `ASSERT_ALWAYS(a_no_overwrite, !(rd_issue && pend && !pend_move))
  `ASSERT_IMPLY(a_read_in_frame, rd_issue, rd_addr < total)
  `ASSERT_IMPLY(a_emit_count_clear, state == ST_EMIT, count == '0)
  `ASSERT_NEXT(a_last_ends_emit, rd_issue && last_col && last_row, state == ST_LOAD)

endmodule

/* tb/rotation_monitor.sv */
`timescale 1ns / 1ps
// Watches the side register and both streams of the 90-degree matrix rotator,
// predicts every rotated element and compares it with what the block sends.
// Depends on sir90_pkg.
module rotation_monitor #(
  parameter int MAX_SIDE = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sir90_pkg::SIDE_W-1:0] cfg_wdata,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [sir90_pkg::DATA_W-1:0] s_tdata,    // [31:0] pixel_value
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [sir90_pkg::DATA_W-1:0] m_tdata,    // [31:0] rotated_value
  input  logic                         m_tlast,    // last_of_frame
  output int                           mismatches,
  output int                           pending
);

  import sir90_pkg::*;

  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } rotated_pixel_t;

  // Rotated elements still owed by the block, oldest first
  rotated_pixel_t    rotated_due[$];
  logic [DATA_W-1:0] frame_copy [0:STORE_DEPTH-1];
  logic [6:0]        loaded;
  logic [SIDE_W-1:0] side_reg;

  task automatic report_mismatch(input string what);
    $display("%0t ns: rotation mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    int             n;
    int             area;
    rotated_pixel_t want;
    if (rst) begin
      loaded     = '0;
      side_reg   = SIDE_W'(SIDE_RESET);
      mismatches = 0;
      rotated_due.delete();
    end else begin
      // Follow the side register
      if (cfg_we) side_reg = cfg_wdata;

      // Store each input transfer; on the last element queue the rotated frame
      if (s_tvalid && s_tready) begin
        n = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg));
        area = n * n;
        frame_copy[loaded % STORE_DEPTH] = s_tdata;
        loaded = loaded + 7'd1;
        if (loaded >= area) begin
          for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
              want.value = frame_copy[((n - 1 - j) * n + i) % STORE_DEPTH];
              want.last  = (i == n - 1) && (j == n - 1);
              rotated_due.push_back(want);
            end
          end
          loaded = '0;
        end
      end

      // Compare each output transfer with the oldest owed element
      if (m_tvalid && m_tready) begin
        if (rotated_due.size() == 0) begin
          report_mismatch($sformatf("unexpected element %h last %b", m_tdata, m_tlast));
        end else begin
          want = rotated_due.pop_front();
          if (m_tdata !== want.value)
            report_mismatch($sformatf("rotated_value got %h want %h", m_tdata, want.value));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last_of_frame got %b want %b", m_tlast, want.last));
        end
      end
    end
    pending <= rotated_due.size();
  end

endmodule

/* tb/square_image_rotate_90_clockwise_test.sv */
`timescale 1ns / 1ps
// Top of the rotator testbench: drives side writes and matrix elements with
// random gaps and stalls, and gives the verdict. Depends on sir90_pkg,
// square_image_rotate_90_clockwise and rotation_monitor.
module square_image_rotate_90_clockwise_test;

  import sir90_pkg::*;

  localparam int MAX_SIDE       = 8;
  localparam int ITEMS          = 430;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 1000;

  logic              clk;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [SIDE_W-1:0] cfg_wdata = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata   = '0;   // [31:0] pixel_value
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [DATA_W-1:0] m_tdata;          // [31:0] rotated_value
  logic              m_tlast;          // last_of_frame

  int mismatches;
  int pending;

  // Stimulus bookkeeping
  logic [SIDE_W-1:0] side_now = SIDE_W'(SIDE_RESET);
  int                fill       = 0;
  int                items_sent = 0;
  bit                tx_calm    = 1'b0;

  // Receiver pacing
  bit rx_calm;
  int rx_hold;
  int idle_cycles;

  square_image_rotate_90_clockwise #(
    .MAX_SIDE(MAX_SIDE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  rotation_monitor #(
    .MAX_SIDE(MAX_SIDE)
  ) monitor (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Number of elements in one frame for a raw side value
  function automatic int frame_area(input logic [SIDE_W-1:0] side);
    int n;
    n = (side == 0) ? 1 : ((side > MAX_SIDE) ? MAX_SIDE : int'(side));
    return n * n;
  endfunction

  // Mostly random words, now and then an extreme
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Offer one element after a random gap and hold it until the transfer
  task automatic send_pixel(input logic [DATA_W-1:0] value);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    fill++;
    if (fill >= frame_area(side_now)) fill = 0;
  endtask

  // Fill the current frame up to its last element
  task automatic finish_frame();
    do send_pixel(pick_value()); while (fill != 0);
  endtask

  // Drain all owed results, let the block settle, then write the side
  task automatic write_side(input logic [SIDE_W-1:0] side);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= side;
    @(posedge clk);
    cfg_we   <= 1'b0;
    side_now = side;
  endtask

  // Stall the output for a random number of cycles after each transfer
  always @(posedge clk) begin : rx_pace
    int stall;
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
      rx_calm  <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      if (m_tlast) rx_calm <= ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        m_tready <= 1'b0;
        rx_hold  <= stall;
      end
    end else if (!m_tready) begin
      if (rx_hold <= 1) begin
        m_tready <= 1'b1;
        rx_hold  <= 0;
      end else begin
        rx_hold <= rx_hold - 1;
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("square_image_rotate_90_clockwise_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [SIDE_W-1:0] side;
    int                part;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Zero side acts as one: single-element frames at both signed extremes
    write_side(4'd0);
    send_pixel(32'h8000_0000);
    write_side(4'd1);
    send_pixel(32'h7fff_ffff);

    // Two by two frame with corner words
    write_side(4'd2);
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0001);
    send_pixel(32'h8000_0000);

    // Shrink the side mid-frame past the load count: next element emits
    write_side(4'd3);
    repeat (5) send_pixel(pick_value());
    write_side(4'd2);
    send_pixel(pick_value());

    // Grow the side mid-frame: loading carries on to the larger frame
    repeat (2) send_pixel(pick_value());
    write_side(4'd3);
    finish_frame();

    // Side above the maximum acts as the maximum
    write_side(4'd15);
    finish_frame();

    // Random frames, mostly small, some broken by a side change mid-frame
    while (items_sent < ITEMS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        7, 8:    side = SIDE_W'($urandom_range(5, 7));
        9:       side = SIDE_W'($urandom_range(8, 15));
        default: side = SIDE_W'($urandom_range(0, 4));
      endcase
      if (side != side_now || $urandom_range(0, 3) == 0) write_side(side);
      if (frame_area(side) > 1 && $urandom_range(0, 4) == 0) begin
        part = $urandom_range(1, frame_area(side) - 1);
        repeat (part) send_pixel(pick_value());
        write_side(SIDE_W'($urandom_range(0, 7)));
      end
      finish_frame();
    end

    // Drain and give the verdict
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("square_image_rotate_90_clockwise_test: PASS");
    end else begin
      $display("square_image_rotate_90_clockwise_test: FAIL");
    end
    $finish;
  end

endmodule
